FILE: rtl/core/gcc_pkg.sv
// ---------------------------------------------------------------------------
// gcc_pkg: shared types and constants for the gamepad command conditioner
// Register indexes, fixed-point limits, sequencer states, the lane control struct and the axis normalizer.
// ---------------------------------------------------------------------------
package gcc_pkg;

  localparam int unsigned CfgW = 17;

  // register indexes
  typedef enum logic [2:0] {
    REG_VX_MAX    = 3'd0,
    REG_VY_MAX    = 3'd1,
    REG_YAW_MAX   = 3'd2,
    REG_DEADZONE  = 3'd3,
    REG_THRESHOLD = 3'd4,
    REG_HOLD_MS   = 3'd5
  } reg_idx_t;

  localparam logic [15:0] DeadzoneLimit  = 16'd62259;
  localparam logic [16:0] ThresholdLimit = 17'd65536;
  localparam logic [31:0] ReleaseMs      = 32'd200;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_MUL  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // lane start command
  typedef struct packed {
    logic        start;
    logic [15:0] dz;
  } lane_ctl_t;

  // normalize a raw axis to Q.16, range [-65536, 65536]
  function automatic logic signed [17:0] normalize(input logic signed [15:0] raw);
    logic [17:0] q;
    begin
      // floor(r*65536/32767) = r*2 + floor(2r/32767) adjust
      q = {2'b0, raw[14:0], 1'b0} + 18'(({17'd0, raw[14:0]} << 1) >= 32'd32767 ? 1 : 0);
      if (raw[15]) begin
        normalize = 18'(signed'(raw)) <<< 1;
      end else begin
        normalize = (raw == 16'sd32767) ? 18'sd65536 : signed'(q);
      end
    end
  endfunction

endpackage

FILE: rtl/core/gcc_lane.sv
// ---------------------------------------------------------------------------
// gcc_lane: one stick lane
// Deadzone rescale by a restoring divider, then scale and negate.
// ---------------------------------------------------------------------------
module gcc_lane
  import gcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  lane_ctl_t           ctl,
  input  logic signed [17:0]  n,
  input  logic [15:0]         scale,
  output logic                done,
  output logic signed [16:0]  cmd
);

  logic [16:0] mag_in;
  logic [16:0] diff_in;
  logic [16:0] den;
  logic [16:0] pr;
  logic [16:0] dsr;
  logic [16:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic        zero;
  logic        neg;
  logic        mul;
  logic [17:0] trial;
  logic [32:0] prod;

  // magnitude of the axis and its excess over the deadzone
  assign mag_in  = n[17] ? 17'(-n) : 17'(n);
  assign diff_in = mag_in - {1'b0, ctl.dz};

  // partial remainder with the next dividend bit shifted in
  assign trial = {pr, dsr[16]};
  assign prod  = quo * scale;

  // shift-subtract division, one quotient bit per cycle, then one multiply
  // dividend is (mag-dz) << 16: top 16 bits preload the remainder, 17 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mul  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= ~n[17];
        den  <= 17'd65536 - {1'b0, ctl.dz};
        zero <= mag_in < {1'b0, ctl.dz};
        pr   <= {1'b0, diff_in[16:1]};
        dsr  <= {diff_in[0], 16'd0};
        quo  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          pr  <= 17'(trial - {1'b0, den});
          quo <= {quo[15:0], 1'b1};
        end else begin
          pr  <= trial[16:0];
          quo <= {quo[15:0], 1'b0};
        end
        dsr <= {dsr[15:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          mul  <= 1'b1;
        end
      end else if (mul) begin
        mul  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // scale, truncate toward zero, negate for a positive stick
  always_ff @(posedge clk) begin
    if (mul) begin
      if (zero) cmd <= '0;
      else cmd <= neg ? -signed'(prod[32:16]) : signed'(prod[32:16]);
    end
  end

endmodule

FILE: rtl/core/gcc_merge.sv
// ---------------------------------------------------------------------------
// gcc_merge: button decode and pulse debouncers
// Thresholds, chords with release debounce, long-press timers.
// ---------------------------------------------------------------------------
module gcc_merge
  import gcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [31:0]        now,
  input  logic               conn,
  input  logic signed [17:0] lt,
  input  logic signed [17:0] rt,
  input  logic signed [17:0] px,
  input  logic signed [17:0] py,
  input  logic [5:0]         btn,
  input  logic [3:0]         hat,
  input  logic [16:0]        thr_reg,
  input  logic [15:0]        hold_ms,
  output logic [11:0]        pressed,
  output logic [4:0]         pulses
);

  logic signed [17:0] thr;
  logic [5:0] b;
  logic [3:0] h;
  logic b_lt, b_rt, b_l, b_r, b_u, b_d;
  logic [2:0] chord_raw;
  logic [1:0] hold_raw;
  logic [1:0] hold_fire;

  logic [2:0]  chord_latched, chord_low_seen;
  logic [31:0] chord_low_time [3];
  logic [1:0]  hold_active, hold_fired, hold_low_seen;
  logic [31:0] hold_start_time [2];
  logic [31:0] hold_low_time [2];

  // decode buttons
  always_comb begin
    thr = signed'({1'b0, (thr_reg > ThresholdLimit) ? ThresholdLimit : thr_reg});
    b = conn ? btn : 6'd0;
    h = conn ? hat : 4'd0;
    b_lt = lt >= thr;
    b_rt = rt >= thr;
    b_l = (px <= -thr) || h[3];
    b_r = (px >= thr) || h[1];
    b_u = (py <= -thr) || h[0];
    b_d = (py >= thr) || h[2];
    pressed = {b_d, b_u, b_r, b_l, b_rt, b_lt, b};
    chord_raw = {b[4] & b[5], b_rt & b[5] & b[2], b_lt & b[4] & b[3]};
    hold_raw = {b_r, b_l};
  end

  // long press fires on a fresh press with zero hold, or once the hold elapses
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (hold_active[k])
        hold_fire[k] = hold_raw[k] && !hold_fired[k] &&
                       ((now - hold_start_time[k]) >= {16'd0, hold_ms});
      else
        hold_fire[k] = hold_raw[k] && (hold_ms == 16'd0);
    end
  end

  // pulse state, updated once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_latched <= '0;
      chord_low_seen <= '0;
      hold_active <= '0;
      hold_fired <= '0;
      hold_low_seen <= '0;
      pulses <= '0;
      for (int k = 0; k < 3; k++) chord_low_time[k] <= '0;
      for (int k = 0; k < 2; k++) begin
        hold_start_time[k] <= '0;
        hold_low_time[k] <= '0;
      end
    end else if (step) begin
      for (int k = 0; k < 3; k++) begin
        pulses[k] <= chord_raw[k] & ~chord_latched[k];
        if (chord_raw[k]) begin
          chord_low_seen[k] <= 1'b0;
          if (!chord_latched[k]) chord_latched[k] <= 1'b1;
        end else if (!chord_low_seen[k]) begin
          chord_low_seen[k] <= 1'b1;
          chord_low_time[k] <= now;
        end else if (chord_latched[k] && (now - chord_low_time[k]) >= ReleaseMs) begin
          chord_latched[k] <= 1'b0;
        end
      end
      for (int k = 0; k < 2; k++) begin
        pulses[3+k] <= hold_fire[k];
        if (hold_raw[k]) begin
          hold_low_seen[k] <= 1'b0;
          if (!hold_active[k]) begin
            hold_active[k] <= 1'b1;
            hold_start_time[k] <= now;
            hold_fired[k] <= hold_fire[k];
          end else if (hold_fire[k]) begin
            hold_fired[k] <= 1'b1;
          end
        end else if (!hold_low_seen[k]) begin
          hold_low_seen[k] <= 1'b1;
          hold_low_time[k] <= now;
        end else if (hold_active[k] && (now - hold_low_time[k]) >= ReleaseMs) begin
          hold_active[k] <= 1'b0;
          hold_fired[k] <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/gamepad_command_conditioner_core.sv
// ---------------------------------------------------------------------------
// gamepad_command_conditioner_core: gamepad sample to motion command
// Three stick lanes with deadzone rescale, button decode and pulse logic.
// ---------------------------------------------------------------------------
//  channel | signals                    | direction
//  --------+----------------------------+----------
//  sample  | in_valid/in_ready, fields  | in
//  command | out_valid/out_ready, fields| out
//  config  | cfg_we, cfg_index, cfg_data| in
// A transaction runs from accept through load, 17 divider steps in each
// stick lane (all three in parallel), one multiply and one sequencer step to
// result valid. A result holds in the output register until taken; the
// next sample is accepted from the cycle after the result is taken, so a new
// sample is never taken while one is in flight. rst is synchronous and restores
// register defaults and clears all pulse state.
module gamepad_command_conditioner_core
  import gcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         now_ms,
  input  logic                connected,
  input  logic signed [15:0]  raw_left_x,
  input  logic signed [15:0]  raw_left_y,
  input  logic signed [15:0]  raw_right_x,
  input  logic signed [15:0]  raw_left_trigger,
  input  logic signed [15:0]  raw_right_trigger,
  input  logic signed [15:0]  raw_pad_x,
  input  logic signed [15:0]  raw_pad_y,
  input  logic [5:0]          button_bits,
  input  logic [3:0]          hat_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  vx,
  output logic signed [16:0]  vy,
  output logic signed [16:0]  yaw_cmd,
  output logic [11:0]         pressed_bits,
  output logic                standup_pulse,
  output logic                liedown_pulse,
  output logic                estop_pulse,
  output logic                prev_pulse,
  output logic                next_pulse,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  logic [15:0] vx_max, vy_max, yaw_max, deadzone, hold_ms;
  logic [16:0] digital_threshold;
  state_t state, state_next;
  logic accept;
  lane_ctl_t ctl;
  logic [2:0] done;
  logic [11:0] pressed;
  logic [4:0] pulses;
  logic signed [17:0] n_lx, n_ly, n_rx, n_lt, n_rt, n_px, n_py;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vx_max <= 16'd4096;
      vy_max <= 16'd4096;
      yaw_max <= 16'd8192;
      deadzone <= 16'd6554;
      digital_threshold <= 17'd32768;
      hold_ms <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VX_MAX:    vx_max <= cfg_data[15:0];
        REG_VY_MAX:    vy_max <= cfg_data[15:0];
        REG_YAW_MAX:   yaw_max <= cfg_data[15:0];
        REG_DEADZONE:  deadzone <= cfg_data[15:0];
        REG_THRESHOLD: digital_threshold <= cfg_data;
        REG_HOLD_MS:   hold_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  // normalize axes
  always_comb begin
    n_lx = connected ? normalize(raw_left_x) : '0;
    n_ly = connected ? normalize(raw_left_y) : '0;
    n_rx = connected ? normalize(raw_right_x) : '0;
    n_lt = connected ? normalize(raw_left_trigger) : '0;
    n_rt = connected ? normalize(raw_right_trigger) : '0;
    n_px = connected ? normalize(raw_pad_x) : '0;
    n_py = connected ? normalize(raw_pad_y) : '0;
  end

  assign ctl.start = accept;
  assign ctl.dz = (deadzone > DeadzoneLimit) ? DeadzoneLimit : deadzone;

  gcc_lane u_lane_vx (.clk, .rst, .ctl, .n(n_ly), .scale(vx_max), .done(done[0]), .cmd(vx));
  gcc_lane u_lane_vy (.clk, .rst, .ctl, .n(n_lx), .scale(vy_max), .done(done[1]), .cmd(vy));
  gcc_lane u_lane_yaw (.clk, .rst, .ctl, .n(n_rx), .scale(yaw_max), .done(done[2]),
    .cmd(yaw_cmd));

  gcc_merge u_merge (
    .clk, .rst, .step(accept), .now(now_ms), .conn(connected),
    .lt(n_lt), .rt(n_rt), .px(n_px), .py(n_py), .btn(button_bits), .hat(hat_bits),
    .thr_reg(digital_threshold), .hold_ms, .pressed, .pulses
  );

  // hold the decoded buttons with the transaction
  always_ff @(posedge clk) begin
    if (accept) pressed_bits <= pressed;
  end

  assign {next_pulse, prev_pulse, estop_pulse, liedown_pulse, standup_pulse} = pulses;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_DIV;
      ST_DIV:  if (done[0]) state_next = ST_OUT;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

`ifndef SYNTHESIS
  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    done[0] |-> done[1] && done[2]) else $error("lanes out of step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done[0])) else $error("result without lane done");
`endif

endmodule
